// ===== rtl/hbp_pkg.sv =====
package hbp_pkg;

    localparam logic [26:0] HASH_MUL    = 27'h45d9f3b;
    localparam int          HASH_SHIFT  = 16;
    localparam logic [31:0] SMALL_LIMIT = 32'd121;
    localparam int          NUM_PRIMES  = 25;

    localparam logic [6:0] SMALL_PRIMES [NUM_PRIMES] = '{
        7'd2, 7'd3, 7'd5, 7'd7, 7'd11, 7'd13, 7'd17, 7'd19, 7'd23, 7'd29, 7'd31, 7'd37,
        7'd41, 7'd43, 7'd47, 7'd53, 7'd59, 7'd61, 7'd67, 7'd71, 7'd73, 7'd79, 7'd83,
        7'd89, 7'd97
    };

    localparam logic [15:0] BASE_ROM [256] = '{
        16'd15591, 16'd2018, 16'd166, 16'd7429, 16'd8064, 16'd16045, 16'd10503,
        16'd4399, 16'd1949, 16'd1295, 16'd2776, 16'd3620, 16'd560, 16'd3128,
        16'd5212, 16'd2657, 16'd2300, 16'd2021, 16'd4652, 16'd1471, 16'd9336,
        16'd4018, 16'd2398, 16'd20462, 16'd10277, 16'd8028, 16'd2213, 16'd6219,
        16'd620, 16'd3763, 16'd4852, 16'd5012, 16'd3185, 16'd1333, 16'd6227,
        16'd5298, 16'd1074, 16'd2391, 16'd5113, 16'd7061, 16'd803, 16'd1269,
        16'd3875, 16'd422, 16'd751, 16'd580, 16'd4729, 16'd10239, 16'd746,
        16'd2951, 16'd556, 16'd2206, 16'd3778, 16'd481, 16'd1522, 16'd3476,
        16'd481, 16'd2487, 16'd3266, 16'd5633, 16'd488, 16'd3373, 16'd6441,
        16'd3344, 16'd17, 16'd15105, 16'd1490, 16'd4154, 16'd2036, 16'd1882,
        16'd1813, 16'd467, 16'd3307, 16'd14042, 16'd6371, 16'd658, 16'd1005,
        16'd903, 16'd737, 16'd1887, 16'd7447, 16'd1888, 16'd2848, 16'd1784,
        16'd7559, 16'd3400, 16'd951, 16'd13969, 16'd4304, 16'd177, 16'd41,
        16'd19875, 16'd3110, 16'd13221, 16'd8726, 16'd571, 16'd7043, 16'd6943,
        16'd1199, 16'd352, 16'd6435, 16'd165, 16'd1169, 16'd3315, 16'd978,
        16'd233, 16'd3003, 16'd2562, 16'd2994, 16'd10587, 16'd10030, 16'd2377,
        16'd1902, 16'd5354, 16'd4447, 16'd1555, 16'd263, 16'd27027, 16'd2283,
        16'd305, 16'd669, 16'd1912, 16'd601, 16'd6186, 16'd429, 16'd1930,
        16'd14873, 16'd1784, 16'd1661, 16'd524, 16'd3577, 16'd236, 16'd2360,
        16'd6146, 16'd2850, 16'd55637, 16'd1753, 16'd4178, 16'd8466, 16'd222,
        16'd2579, 16'd2743, 16'd2031, 16'd2226, 16'd2276, 16'd374, 16'd2132,
        16'd813, 16'd23788, 16'd1610, 16'd4422, 16'd5159, 16'd1725, 16'd3597,
        16'd3366, 16'd14336, 16'd579, 16'd165, 16'd1375, 16'd10018, 16'd12616,
        16'd9816, 16'd1371, 16'd536, 16'd1867, 16'd10864, 16'd857, 16'd2206,
        16'd5788, 16'd434, 16'd8085, 16'd17618, 16'd727, 16'd3639, 16'd1595,
        16'd4944, 16'd2129, 16'd2029, 16'd8195, 16'd8344, 16'd6232, 16'd9183,
        16'd8126, 16'd1870, 16'd3296, 16'd7455, 16'd8947, 16'd25017, 16'd541,
        16'd19115, 16'd368, 16'd566, 16'd5674, 16'd411, 16'd522, 16'd1027,
        16'd8215, 16'd2050, 16'd6544, 16'd10049, 16'd614, 16'd774, 16'd2333,
        16'd3007, 16'd35201, 16'd4706, 16'd1152, 16'd1785, 16'd1028, 16'd1540,
        16'd3743, 16'd493, 16'd4474, 16'd2521, 16'd26845, 16'd8354, 16'd864,
        16'd18915, 16'd5465, 16'd2447, 16'd42, 16'd4511, 16'd1660, 16'd166,
        16'd1249, 16'd6259, 16'd2553, 16'd304, 16'd272, 16'd7286, 16'd73,
        16'd6554, 16'd899, 16'd2816, 16'd5197, 16'd13330, 16'd7054, 16'd2818,
        16'd3199, 16'd811, 16'd922, 16'd350, 16'd7514, 16'd4452, 16'd3449,
        16'd2663, 16'd4708, 16'd418, 16'd1621, 16'd1171, 16'd3471, 16'd88,
        16'd11345, 16'd412, 16'd1559, 16'd194
    };

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_TRIAL = 12'b0000_0000_0010,
        S_RED   = 12'b0000_0000_0100,
        S_DISP  = 12'b0000_0000_1000,
        S_HASH1 = 12'b0000_0001_0000,
        S_HASH2 = 12'b0000_0010_0000,
        S_HASH3 = 12'b0000_0100_0000,
        S_STRIP = 12'b0000_1000_0000,
        S_LOOP  = 12'b0001_0000_0000,
        S_MUL   = 12'b0010_0000_0000,
        S_CHECK = 12'b0100_0000_0000,
        S_FLOOP = 12'b1000_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        OP_TRIAL,
        OP_BASE,
        OP_ACC,
        OP_SQ,
        OP_FIN
    } op_t;

endpackage

// ===== rtl/hashed_base_prime_test32_core.sv =====
// Channel  | Signals                    | Direction
// ---------+----------------------------+----------
// command  | start, number[31:0] (busy out) | in
// result   | done, is_prime             | out
//
// A transaction is taken when start is high and busy is low; busy stays high
// until the answer is ready, then done pulses for one cycle with is_prime.
// Every modular reduction runs one bit per cycle through a single 64-by-32
// restoring reducer, set up beforehand and followed by a dispatch state: trial
// division takes up to 25 reductions, the Miller-Rabin test up to 64. Reset is
// asynchronous and returns the block to idle. The receiver cannot stall the
// result.
module hashed_base_prime_test32_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] number,
    output logic        done,
    output logic        is_prime
);
    import hbp_pkg::*;

    state_t      state_reg, state_next;
    op_t         op_reg, op_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] m_reg, m_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [4:0]  pidx_reg, pidx_next;
    logic [39:0] h1_reg, h1_next;
    logic [23:0] h2_reg, h2_next;
    logic [31:0] d_reg, d_next;
    logic [4:0]  s_reg, s_next;
    logic [4:0]  r_reg, r_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] sq_reg, sq_next;
    logic        done_reg, done_next;
    logic        prime_reg, prime_next;

    logic [32:0] trial_rem;
    logic [31:0] mul_a, mul_b;
    logic [58:0] h1_prod;
    logic [47:0] h2_prod;
    logic [7:0]  hidx;
    logic [31:0] xm1;

    assign xm1 = x_reg - 32'd1;
    assign trial_rem = {rem_reg, dvd_reg[63]};
    assign h1_prod = (x_reg ^ (x_reg >> HASH_SHIFT)) * HASH_MUL;
    assign h2_prod = (h1_reg[23:0] ^ h1_reg[39:16]) * HASH_MUL[23:0];
    assign hidx = h2_reg[7:0] ^ h2_reg[23:16];

    always_comb
    begin
        case (op_reg)
            OP_ACC:
            begin
                mul_a = acc_reg;
                mul_b = sq_reg;
            end
            OP_FIN:
            begin
                mul_a = acc_reg;
                mul_b = acc_reg;
            end
            default:
            begin
                mul_a = sq_reg;
                mul_b = sq_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        m_next     = m_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        pidx_next  = pidx_reg;
        h1_next    = h1_reg;
        h2_next    = h2_reg;
        d_next     = d_reg;
        s_next     = s_reg;
        r_next     = r_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        done_next  = 1'b0;
        prime_next = prime_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    x_next     = number;
                    pidx_next  = '0;
                    state_next = S_TRIAL;
                end
            end
            S_TRIAL:
            begin
                dvd_next   = {32'd0, x_reg};
                m_next     = {25'd0, SMALL_PRIMES[pidx_reg]};
                rem_next   = '0;
                cnt_next   = '0;
                op_next    = OP_TRIAL;
                state_next = S_RED;
            end
            S_RED:
            begin
                // One restoring step: shift in a dividend bit, subtract if it fits.
                if (trial_rem >= {1'b0, m_reg})
                begin
                    rem_next = 32'(trial_rem - {1'b0, m_reg});
                end
                else
                begin
                    rem_next = trial_rem[31:0];
                end
                dvd_next = {dvd_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (op_reg)
                    OP_TRIAL:
                    begin
                        if (rem_reg == 32'd0)
                        begin
                            prime_next = (x_reg == m_reg);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (pidx_reg == 5'(NUM_PRIMES - 1))
                        begin
                            if (x_reg < SMALL_LIMIT)
                            begin
                                prime_next = (x_reg > 32'd1);
                                done_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_HASH1;
                            end
                        end
                        else
                        begin
                            pidx_next  = pidx_reg + 5'd1;
                            state_next = S_TRIAL;
                        end
                    end
                    OP_BASE:
                    begin
                        sq_next    = rem_reg;
                        acc_next   = 32'd1;
                        d_next     = xm1;
                        s_next     = '0;
                        state_next = S_STRIP;
                    end
                    OP_ACC:
                    begin
                        acc_next   = rem_reg;
                        op_next    = OP_SQ;
                        state_next = S_MUL;
                    end
                    OP_SQ:
                    begin
                        sq_next    = rem_reg;
                        d_next     = d_reg >> 1;
                        state_next = S_LOOP;
                    end
                    default:
                    begin
                        acc_next   = rem_reg;
                        r_next     = r_reg + 5'd1;
                        state_next = S_FLOOP;
                    end
                endcase
            end
            S_HASH1:
            begin
                h1_next    = h1_prod[39:0];
                state_next = S_HASH2;
            end
            S_HASH2:
            begin
                h2_next    = h2_prod[23:0];
                state_next = S_HASH3;
            end
            S_HASH3:
            begin
                dvd_next   = {48'd0, BASE_ROM[hidx]};
                m_next     = x_reg;
                rem_next   = '0;
                cnt_next   = '0;
                op_next    = OP_BASE;
                state_next = S_RED;
            end
            S_STRIP:
            begin
                // The number is odd here, so d is nonzero and this ends.
                if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + 5'd1;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (d_reg == 32'd0)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    op_next    = d_reg[0] ? OP_ACC : OP_SQ;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                dvd_next   = mul_a * mul_b;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_RED;
            end
            S_CHECK:
            begin
                if (acc_reg == 32'd1)
                begin
                    prime_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    r_next     = '0;
                    state_next = S_FLOOP;
                end
            end
            S_FLOOP:
            begin
                if (r_reg == s_reg)
                begin
                    prime_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (acc_reg == xm1)
                begin
                    prime_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    op_next    = OP_FIN;
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        x_reg     <= x_next;
        m_reg     <= m_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        pidx_reg  <= pidx_next;
        h1_reg    <= h1_next;
        h2_reg    <= h2_next;
        d_reg     <= d_next;
        s_reg     <= s_next;
        r_reg     <= r_next;
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        prime_reg <= prime_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign is_prime = prime_reg;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RED) |-> (rem_reg < m_reg))
        else $error("partial remainder out of range");
`endif

endmodule
